@@ rtl/mh64_pkg.sv @@
`timescale 1ns / 1ps

package mh64_pkg;

   localparam logic [31:0] MUL_CONST  = 32'h5bd1e995;
   localparam int          MIX_SHIFT  = 24;
   localparam int          FIN_SHIFT1 = 18;
   localparam int          FIN_SHIFT2 = 22;
   localparam int          FIN_SHIFT3 = 17;
   localparam int          FIN_SHIFT4 = 19;
   localparam logic [15:0] MAX_LENGTH = 16'd512;

   // CSR byte addresses
   localparam logic [1:0]  CSR_ADDR_SEED = 2'd0;
   localparam logic [31:0] SEED_RESET    = 32'd1;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_FULL,
      KIND_TAIL
   } word_kind_type;

   typedef enum logic [1:0] {
      SPEC_NORMAL,
      SPEC_EMPTY,
      SPEC_LONG
   } special_type;

   // One classified word as it travels from front to back
   typedef struct packed {
      logic [31:0]   word;
      word_kind_type kind;
      logic [1:0]    tail_bytes;
      logic          first;
      logic          last;
      logic [31:0]   start_upper;
      special_type   special;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

@@ rtl/murmur64b_string_hash.sv @@
`timescale 1ns / 1ps

// MurmurHash64B over a byte string streamed as little-endian 32-bit words.
// Input channel (req_*): one word per handshake, accepted when req_valid is
// high and req_stall is low. The first word of a string carries
// req_first_word and the total length; the last carries req_last_word and
// 0..4 valid bytes. Result channel (rsp_*): one 64-bit hash per last word,
// {first half, second half}; 0 for an empty string, 1 above 512 bytes.
// CSR port: the seed register at byte address 0, reset value 1; write it
// only while no string is in flight.
// Flow: a front classifier feeds a small word queue, so req_stall only
// rises when that queue is full. The back end shares one 32x32 constant
// multiplier: a full word passes a dequeue and three multiplies, a tail
// word a dequeue and one multiply, an empty word a dequeue only, and a
// last word adds four finalize multiplies and a load of the output register.
// Reset (synchronous, active high) empties the queue, clears both halves and
// drops rsp_valid. A stalled result holds in the output register; the back
// end keeps working on queued words until it needs that register again.

module murmur64b_string_hash #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_first_word,
   input  logic        req_last_word,
   input  logic [15:0] req_total_length,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_hash_value,
   // CSR
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [31:0]                seed_ff;
   logic                       push;
   logic                       pop;
   mh64_pkg::entry_type        push_entry;
   mh64_pkg::entry_type        head;
   mh64_pkg::queue_status_type q_status;

   // CSR: zero wait state, seed only
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == mh64_pkg::CSR_ADDR_SEED) ? seed_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= mh64_pkg::SEED_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr == mh64_pkg::CSR_ADDR_SEED) begin
         seed_ff <= csr_pwdata;
      end
   end

   // front: classify each word and start value
   mh64_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_word    (req_data_word),
      .req_valid_bytes  (req_valid_bytes),
      .req_first_word   (req_first_word),
      .req_last_word    (req_last_word),
      .req_total_length (req_total_length),
      .seed             (seed_ff),
      .q_status         (q_status),
      .push             (push),
      .push_entry       (push_entry)
   );

   // word queue between front and back
   mh64_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   // back: mixing, tail, finalize, output register
   mh64_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

@@ rtl/mh64_front.sv @@
`timescale 1ns / 1ps

module mh64_front (
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [31:0]          req_data_word,
   input  logic [2:0]           req_valid_bytes,
   input  logic                 req_first_word,
   input  logic                 req_last_word,
   input  logic [15:0]          req_total_length,
   input  logic [31:0]          seed,
   input  mh64_pkg::queue_status_type q_status,
   output logic                 push,
   output mh64_pkg::entry_type  push_entry
);

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   always_comb begin
      push_entry             = '0;
      push_entry.word        = req_data_word;
      push_entry.first       = req_first_word;
      push_entry.last        = req_last_word;
      push_entry.start_upper = seed ^ {16'd0, req_total_length};
      push_entry.tail_bytes  = req_valid_bytes[1:0];
      // counts above four act as four
      if (req_valid_bytes >= 3'd4) begin
         push_entry.kind = mh64_pkg::KIND_FULL;
      end else if (req_valid_bytes == 3'd0) begin
         push_entry.kind = mh64_pkg::KIND_NONE;
      end else begin
         push_entry.kind = mh64_pkg::KIND_TAIL;
      end
      if (req_total_length == 16'd0) begin
         push_entry.special = mh64_pkg::SPEC_EMPTY;
      end else if (req_total_length > mh64_pkg::MAX_LENGTH) begin
         push_entry.special = mh64_pkg::SPEC_LONG;
      end else begin
         push_entry.special = mh64_pkg::SPEC_NORMAL;
      end
   end

endmodule

@@ rtl/mh64_queue.sv @@
`timescale 1ns / 1ps

module mh64_queue #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  mh64_pkg::entry_type        push_entry,
   input  logic                       pop,
   output mh64_pkg::entry_type        head,
   output mh64_pkg::queue_status_type status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   mh64_pkg::entry_type slots_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] rd_ptr_ff;
   logic [CW-1:0] count_ff;

   assign head         = slots_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CW'(DEPTH));

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      bump = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

@@ rtl/mh64_back.sv @@
`timescale 1ns / 1ps

module mh64_back (
   input  logic                       clock,
   input  logic                       reset,
   input  mh64_pkg::entry_type        head,
   input  mh64_pkg::queue_status_type q_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [63:0]                rsp_hash_value
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_K1,
      S_K2,
      S_K3,
      S_TAIL,
      S_F1,
      S_F2,
      S_F3,
      S_F4,
      S_OUT
   } state_type;

   state_type             state_ff;
   mh64_pkg::entry_type   ent_ff;
   mh64_pkg::special_type special_ff;
   logic [31:0] upper_ff;
   logic [31:0] lower_ff;
   logic        ngl_ff;
   logic [31:0] t_ff;
   logic [31:0] h1_ff;
   logic [31:0] h2_ff;
   logic        rsp_valid_ff;
   logic [63:0] rsp_hash_value_ff;

   logic [31:0] mul_a;
   logic [31:0] mul_p;
   logic [31:0] tail_mask;
   logic        out_free;
   logic        out_load;

   assign pop            = (state_ff == S_IDLE) && !q_status.empty;
   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign out_load       = (state_ff == S_OUT) && out_free;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_value_ff;

   always_comb begin
      case (ent_ff.tail_bytes)
         2'd1:    tail_mask = 32'h0000_00ff;
         2'd2:    tail_mask = 32'h0000_ffff;
         default: tail_mask = 32'h00ff_ffff;
      endcase
   end

   // single shared multiplier, low 32 bits of the product
   always_comb begin
      case (state_ff)
         S_K1:    mul_a = ent_ff.word;
         S_K2:    mul_a = t_ff ^ (t_ff >> mh64_pkg::MIX_SHIFT);
         S_K3:    mul_a = ngl_ff ? lower_ff : upper_ff;
         S_TAIL:  mul_a = lower_ff ^ (ent_ff.word & tail_mask);
         S_F1:    mul_a = upper_ff ^ (lower_ff >> mh64_pkg::FIN_SHIFT1);
         S_F2:    mul_a = h2_ff ^ (h1_ff >> mh64_pkg::FIN_SHIFT2);
         S_F3:    mul_a = h1_ff ^ (h2_ff >> mh64_pkg::FIN_SHIFT3);
         S_F4:    mul_a = h2_ff ^ (h1_ff >> mh64_pkg::FIN_SHIFT4);
         default: mul_a = '0;
      endcase
   end

   assign mul_p = mul_a * mh64_pkg::MUL_CONST;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         upper_ff          <= '0;
         lower_ff          <= '0;
         ngl_ff            <= 1'b0;
         special_ff        <= mh64_pkg::SPEC_NORMAL;
         rsp_valid_ff      <= 1'b0;
         ent_ff            <= '0;
         t_ff              <= '0;
         h1_ff             <= '0;
         h2_ff             <= '0;
         rsp_hash_value_ff <= '0;
      end else begin
         rsp_valid_ff <= out_load || (rsp_valid_ff && rsp_stall);
         case (state_ff)
            S_IDLE: begin
               if (pop) begin
                  ent_ff <= head;
                  if (head.first) begin
                     upper_ff   <= head.start_upper;
                     lower_ff   <= '0;
                     ngl_ff     <= 1'b0;
                     special_ff <= head.special;
                  end
                  case (head.kind)
                     mh64_pkg::KIND_FULL: state_ff <= S_K1;
                     mh64_pkg::KIND_TAIL: state_ff <= S_TAIL;
                     default:             state_ff <= head.last ? S_F1 : S_IDLE;
                  endcase
               end
            end
            S_K1: begin
               t_ff     <= mul_p;
               state_ff <= S_K2;
            end
            S_K2: begin
               t_ff     <= mul_p;
               state_ff <= S_K3;
            end
            S_K3: begin
               if (ngl_ff) begin
                  lower_ff <= mul_p ^ t_ff;
               end else begin
                  upper_ff <= mul_p ^ t_ff;
               end
               ngl_ff   <= !ngl_ff;
               state_ff <= ent_ff.last ? S_F1 : S_IDLE;
            end
            S_TAIL: begin
               lower_ff <= mul_p;
               state_ff <= ent_ff.last ? S_F1 : S_IDLE;
            end
            S_F1: begin
               h1_ff    <= mul_p;
               h2_ff    <= lower_ff;
               state_ff <= S_F2;
            end
            S_F2: begin
               h2_ff    <= mul_p;
               state_ff <= S_F3;
            end
            S_F3: begin
               h1_ff    <= mul_p;
               state_ff <= S_F4;
            end
            S_F4: begin
               h2_ff    <= mul_p;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  case (special_ff)
                     mh64_pkg::SPEC_EMPTY: rsp_hash_value_ff <= 64'd0;
                     mh64_pkg::SPEC_LONG:  rsp_hash_value_ff <= 64'd1;
                     default:              rsp_hash_value_ff <= {h1_ff, h2_ff};
                  endcase
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

   a_ngl_flips: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_K3) |=> (ngl_ff != $past(ngl_ff)))
      else $error("half select did not alternate after full word");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (out_load && special_ff == mh64_pkg::SPEC_EMPTY) |=> (rsp_hash_value_ff == 64'd0))
      else $error("empty string did not hash to zero");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !out_load)
      else $error("result overwritten while held");

endmodule
